FILE: sv/imm_pkg.sv
// Shared types and codes for the integer matrix multiply unit.
// Used by imm_cell and integer_matrix_multiply_unit; depends on nothing.
package imm_pkg;

  localparam int unsigned MaxDimDefault   = 8;
  localparam int unsigned ElemBitsDefault = 16;
  localparam int unsigned ProductBits     = 35;
  localparam int unsigned DimRegBits      = 4;

  typedef enum logic [1:0] {
    CMD_LOAD_A  = 2'd0,
    CMD_LOAD_B  = 2'd1,
    CMD_COMPUTE = 2'd2,
    CMD_NONE    = 2'd3
  } imm_cmd_t;

  typedef enum logic [1:0] {
    REG_ROWS_A     = 2'd0,
    REG_INNER_SIZE = 2'd1,
    REG_COLS_B     = 2'd2,
    REG_UNUSED     = 2'd3
  } imm_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BLOAD,
    ST_FEED,
    ST_WAIT,
    ST_DRAIN
  } imm_state_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } imm_flow_t;

endpackage

FILE: sv/integer_matrix_multiply_unit.sv
// Integer matrix multiply unit: element stores, sequencer and a chain of MAC cells.
// Load items are accepted while the unit is idle. A compute item first copies B
// into the cells, then per row feeds K elements of A, waits for the chain
// to finish, and drains C product items (one per column, held under stall).
// Reset (rst, synchronous) sets the sizes to 8 and both write pointers to zero;
// the element stores are not cleared.
module integer_matrix_multiply_unit #(
  parameter int unsigned MAX_DIM      = imm_pkg::MaxDimDefault,
  parameter int unsigned ELEMENT_BITS = imm_pkg::ElemBitsDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [1:0]          cfg_index,
  input  logic [3:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          cmd,
  input  logic signed [15:0]  element_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [34:0]  product_value,
  output logic [2:0]          out_row,
  output logic [2:0]          out_col,
  output logic                last
);

  localparam int unsigned Depth = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned IdxW  = $clog2(MAX_DIM);

  logic [imm_pkg::DimRegBits-1:0] rows_a;
  logic [imm_pkg::DimRegBits-1:0] inner_size;
  logic [imm_pkg::DimRegBits-1:0] cols_b;

  imm_pkg::imm_state_t state;
  imm_pkg::imm_state_t state_next;

  logic [AW-1:0]   a_wptr;
  logic [AW-1:0]   b_wptr;
  logic [AW-1:0]   addr;
  logic [IdxW-1:0] r_last;
  logic [IdxW-1:0] k_last;
  logic [IdxW-1:0] c_last;
  logic [IdxW-1:0] i_cnt;
  logic [IdxW-1:0] j_cnt;
  logic [IdxW-1:0] k_cnt;

  logic                    in_fire;
  logic                    out_fire;
  logic                    a_we;
  logic                    b_we;
  logic [ELEMENT_BITS-1:0] elem;
  logic [ELEMENT_BITS-1:0] a_rdata;
  logic [ELEMENT_BITS-1:0] b_rdata;
  logic [AW-1:0]           a_raddr;
  logic [AW-1:0]           b_raddr;

  logic               bw_en;
  logic [IdxW-1:0]    bw_col;
  logic [IdxW-1:0]    bw_k;
  imm_pkg::imm_flow_t feed_flow;
  logic [IdxW-1:0]    feed_k;
  logic               row_done;

  logic [ELEMENT_BITS-1:0]         a_link [MAX_DIM];
  logic [IdxW-1:0]                 k_link [MAX_DIM];
  imm_pkg::imm_flow_t              flow_link [MAX_DIM];
  logic signed [imm_pkg::ProductBits-1:0] acc_bus [MAX_DIM];
  logic [MAX_DIM-1:0]              done_bus;

  function automatic logic [IdxW-1:0] dim_last(input logic [imm_pkg::DimRegBits-1:0] v);
    logic [IdxW-1:0] res;
    if (v == '0) begin
      res = '0;
    end else if (v > imm_pkg::DimRegBits'(MAX_DIM)) begin
      res = IdxW'(MAX_DIM - 1);
    end else begin
      res = IdxW'(v - 4'd1);
    end
    return res;
  endfunction

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign elem     = ELEMENT_BITS'($unsigned(element_value));
  assign a_we     = in_fire && cmd == imm_pkg::CMD_LOAD_A;
  assign b_we     = in_fire && cmd == imm_pkg::CMD_LOAD_B;
  assign a_raddr  = addr;
  assign b_raddr  = addr;
  assign row_done = done_bus[c_last];

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a     <= 4'd8;
      inner_size <= 4'd8;
      cols_b     <= 4'd8;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        imm_pkg::REG_ROWS_A:     rows_a <= cfg_data;
        imm_pkg::REG_INNER_SIZE: inner_size <= cfg_data;
        imm_pkg::REG_COLS_B:     cols_b <= cfg_data;
        default: ;
      endcase
    end
  end

  imm_ram #(.DEPTH(Depth), .WIDTH(ELEMENT_BITS)) u_a_ram (
    .clk(clk), .we(a_we), .waddr(a_wptr), .wdata(elem), .raddr(a_raddr), .rdata(a_rdata)
  );

  imm_ram #(.DEPTH(Depth), .WIDTH(ELEMENT_BITS)) u_b_ram (
    .clk(clk), .we(b_we), .waddr(b_wptr), .wdata(elem), .raddr(b_raddr), .rdata(b_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      imm_pkg::ST_IDLE: begin
        if (in_fire && cmd == imm_pkg::CMD_COMPUTE) begin
          state_next = imm_pkg::ST_BLOAD;
        end
      end
      imm_pkg::ST_BLOAD: begin
        if (k_cnt == k_last && j_cnt == c_last) begin
          state_next = imm_pkg::ST_FEED;
        end
      end
      imm_pkg::ST_FEED: begin
        if (k_cnt == k_last) begin
          state_next = imm_pkg::ST_WAIT;
        end
      end
      imm_pkg::ST_WAIT: begin
        if (row_done) begin
          state_next = imm_pkg::ST_DRAIN;
        end
      end
      imm_pkg::ST_DRAIN: begin
        if (out_fire && j_cnt == c_last) begin
          state_next = (i_cnt == r_last) ? imm_pkg::ST_IDLE : imm_pkg::ST_FEED;
        end
      end
      default: state_next = imm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = state == imm_pkg::ST_IDLE;
    out_valid = state == imm_pkg::ST_DRAIN;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= imm_pkg::ST_IDLE;
      a_wptr    <= '0;
      b_wptr    <= '0;
      bw_en     <= 1'b0;
      feed_flow <= '0;
    end else begin
      state <= state_next;
      if (a_we) begin
        a_wptr <= (a_wptr == AW'(Depth - 1)) ? '0 : a_wptr + 1'b1;
      end
      if (b_we) begin
        b_wptr <= (b_wptr == AW'(Depth - 1)) ? '0 : b_wptr + 1'b1;
      end
      if (state == imm_pkg::ST_DRAIN && state_next == imm_pkg::ST_IDLE) begin
        a_wptr <= '0;
        b_wptr <= '0;
      end
      bw_en           <= state == imm_pkg::ST_BLOAD;
      feed_flow.valid <= state == imm_pkg::ST_FEED;
      feed_flow.first <= k_cnt == '0;
      feed_flow.last  <= k_cnt == k_last;
    end
  end

  always_ff @(posedge clk) begin
    bw_col <= j_cnt;
    bw_k   <= k_cnt;
    feed_k <= k_cnt;
    unique case (state)
      imm_pkg::ST_IDLE: begin
        r_last <= dim_last(rows_a);
        k_last <= dim_last(inner_size);
        c_last <= dim_last(cols_b);
        addr   <= '0;
        i_cnt  <= '0;
        j_cnt  <= '0;
        k_cnt  <= '0;
      end
      imm_pkg::ST_BLOAD: begin
        if (state_next == imm_pkg::ST_FEED) begin
          addr  <= '0;
          j_cnt <= '0;
          k_cnt <= '0;
        end else begin
          addr <= addr + 1'b1;
          if (j_cnt == c_last) begin
            j_cnt <= '0;
            k_cnt <= k_cnt + 1'b1;
          end else begin
            j_cnt <= j_cnt + 1'b1;
          end
        end
      end
      imm_pkg::ST_FEED: begin
        addr  <= addr + 1'b1;
        k_cnt <= (k_cnt == k_last) ? '0 : k_cnt + 1'b1;
      end
      imm_pkg::ST_WAIT: begin
        j_cnt <= '0;
      end
      imm_pkg::ST_DRAIN: begin
        if (out_fire) begin
          if (j_cnt == c_last) begin
            j_cnt <= '0;
            i_cnt <= i_cnt + 1'b1;
          end else begin
            j_cnt <= j_cnt + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
    logic [ELEMENT_BITS-1:0] a_src;
    logic [IdxW-1:0]         k_src;
    imm_pkg::imm_flow_t      flow_src;

    if (g == 0) begin : g_head
      assign a_src    = a_rdata;
      assign k_src    = feed_k;
      assign flow_src = feed_flow;
    end else begin : g_body
      assign a_src    = a_link[g-1];
      assign k_src    = k_link[g-1];
      assign flow_src = flow_link[g-1];
    end

    imm_cell #(.MAX_DIM(MAX_DIM), .ELEMENT_BITS(ELEMENT_BITS)) u_cell (
      .clk(clk),
      .rst(rst),
      .cell_id(IdxW'(g)),
      .bw_en(bw_en),
      .bw_col(bw_col),
      .bw_k(bw_k),
      .bw_data(b_rdata),
      .a_in(a_src),
      .k_in(k_src),
      .flow_in(flow_src),
      .a_out(a_link[g]),
      .k_out(k_link[g]),
      .flow_out(flow_link[g]),
      .acc(acc_bus[g]),
      .done(done_bus[g])
    );
  end

  assign product_value = acc_bus[j_cnt];
  assign out_row       = 3'(i_cnt);
  assign out_col       = 3'(j_cnt);
  assign last          = i_cnt == r_last && j_cnt == c_last;

  a_ready_excl: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input ready while results are pending");

  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    in_fire && cmd == imm_pkg::CMD_COMPUTE |=> !in_ready)
    else $error("compute item did not make the unit busy");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    out_fire && last |=> in_ready)
    else $error("unit not idle after the final product item");

  a_load_ptr: assert property (@(posedge clk) disable iff (rst)
    a_we |=> a_wptr != $past(a_wptr))
    else $error("A write pointer did not advance");

endmodule

FILE: sv/imm_ram.sv
// Simple dual-port element store with registered read data.
// Standalone; used by integer_matrix_multiply_unit.
module imm_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/imm_cell.sv
// One cell of the multiply chain: holds one column of B and one accumulator.
// A elements pass through to the next cell each cycle. Uses imm_pkg.
module imm_cell #(
  parameter int unsigned MAX_DIM      = imm_pkg::MaxDimDefault,
  parameter int unsigned ELEMENT_BITS = imm_pkg::ElemBitsDefault
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [$clog2(MAX_DIM)-1:0]         cell_id,
  input  logic                               bw_en,
  input  logic [$clog2(MAX_DIM)-1:0]         bw_col,
  input  logic [$clog2(MAX_DIM)-1:0]         bw_k,
  input  logic [ELEMENT_BITS-1:0]            bw_data,
  input  logic [ELEMENT_BITS-1:0]            a_in,
  input  logic [$clog2(MAX_DIM)-1:0]         k_in,
  input  imm_pkg::imm_flow_t                 flow_in,
  output logic [ELEMENT_BITS-1:0]            a_out,
  output logic [$clog2(MAX_DIM)-1:0]         k_out,
  output imm_pkg::imm_flow_t                 flow_out,
  output logic signed [imm_pkg::ProductBits-1:0] acc,
  output logic                               done
);

  localparam int unsigned IdxW = $clog2(MAX_DIM);

  logic [ELEMENT_BITS-1:0]          bcol [MAX_DIM];
  logic [ELEMENT_BITS-1:0]          a_q;
  logic [IdxW-1:0]                  k_q;
  imm_pkg::imm_flow_t               flow0;
  imm_pkg::imm_flow_t               flow1;
  logic signed [2*ELEMENT_BITS-1:0] prod;
  logic signed [imm_pkg::ProductBits-1:0] prod_ext;

  always_ff @(posedge clk) begin
    if (bw_en && bw_col == cell_id) begin
      bcol[bw_k] <= bw_data;
    end
  end

  always_ff @(posedge clk) begin
    a_q  <= a_in;
    k_q  <= k_in;
    prod <= $signed(a_q) * $signed(bcol[k_q]);
  end

  assign prod_ext = imm_pkg::ProductBits'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      flow0 <= '0;
      flow1 <= '0;
      done  <= 1'b0;
    end else begin
      flow0 <= flow_in;
      flow1 <= flow0;
      done  <= flow1.valid && flow1.last;
    end
  end

  always_ff @(posedge clk) begin
    if (flow1.valid) begin
      acc <= flow1.first ? prod_ext : acc + prod_ext;
    end
  end

  assign a_out    = a_q;
  assign k_out    = k_q;
  assign flow_out = flow0;

endmodule

FILE: tb/tb.sv
// Testbench for integer_matrix_multiply_unit: loads A and B, issues computes and checks
// every product item against a predictor of its own. Depends on imm_pkg and the block.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned Depth = 64;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned SettleCycles = 20;

  typedef struct {
    logic signed [34:0] value;
    logic [2:0] row;
    logic [2:0] col;
    logic last;
  } product_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [1:0] cfg_index;
  logic [3:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic [1:0] cmd;
  logic signed [15:0] element_value;
  logic out_valid;
  logic out_ready;
  logic signed [34:0] product_value;
  logic [2:0] out_row;
  logic [2:0] out_col;
  logic last;

  logic signed [15:0] a_mem [Depth];
  logic signed [15:0] b_mem [Depth];
  bit a_written [Depth];
  bit b_written [Depth];
  logic [5:0] a_ptr;
  logic [5:0] b_ptr;
  logic [3:0] size_reg [3];
  product_t product_queue [$];

  int errors = 0;
  int items_sent = 0;
  int products_seen = 0;
  int settings_used = 0;
  int cycles = 0;
  bit quiet = 0;

  integer_matrix_multiply_unit dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
    .element_value(element_value), .out_valid(out_valid), .out_ready(out_ready),
    .product_value(product_value), .out_row(out_row), .out_col(out_col), .last(last)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned clamp_dim(logic [3:0] v);
    if (v == 4'd0) return 1;
    if (v > 4'd8) return 8;
    return 32'(v);
  endfunction

  function automatic bit reads_written();
    int unsigned r, k, n;
    r = clamp_dim(size_reg[imm_pkg::REG_ROWS_A]);
    k = clamp_dim(size_reg[imm_pkg::REG_INNER_SIZE]);
    n = clamp_dim(size_reg[imm_pkg::REG_COLS_B]);
    for (int i = 0; i < r * k; i++) if (!a_written[i]) return 0;
    for (int i = 0; i < k * n; i++) if (!b_written[i]) return 0;
    return 1;
  endfunction

  function automatic void predict_item(imm_pkg::imm_cmd_t c, logic signed [15:0] v);
    int unsigned r, k, n;
    longint acc;
    product_t p;
    case (c)
      imm_pkg::CMD_LOAD_A: begin
        a_mem[a_ptr] = v;
        a_written[a_ptr] = 1'b1;
        a_ptr = a_ptr + 6'd1;
      end
      imm_pkg::CMD_LOAD_B: begin
        b_mem[b_ptr] = v;
        b_written[b_ptr] = 1'b1;
        b_ptr = b_ptr + 6'd1;
      end
      imm_pkg::CMD_COMPUTE: begin
        r = clamp_dim(size_reg[imm_pkg::REG_ROWS_A]);
        k = clamp_dim(size_reg[imm_pkg::REG_INNER_SIZE]);
        n = clamp_dim(size_reg[imm_pkg::REG_COLS_B]);
        for (int i = 0; i < r; i++) begin
          for (int j = 0; j < n; j++) begin
            acc = 0;
            for (int m = 0; m < k; m++) begin
              acc += longint'(a_mem[(i * k + m) % Depth]) * longint'(b_mem[(m * n + j) % Depth]);
            end
            p.value = acc[34:0];
            p.row = i[2:0];
            p.col = j[2:0];
            p.last = (i == r - 1) && (j == n - 1);
            product_queue.push_back(p);
          end
        end
        a_ptr = '0;
        b_ptr = '0;
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(imm_pkg::imm_cmd_t c, logic signed [15:0] v);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    element_value <= v;
    do @(posedge clk); while (!in_ready);
    predict_item(c, v);
    if (c != imm_pkg::CMD_NONE) items_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (product_queue.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_size(imm_pkg::imm_reg_t idx, logic [3:0] val);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx != imm_pkg::REG_UNUSED) size_reg[idx] = val;
    settings_used++;
  endtask

  task automatic set_sizes(logic [3:0] r, logic [3:0] k, logic [3:0] n);
    write_size(imm_pkg::REG_ROWS_A, r);
    write_size(imm_pkg::REG_INNER_SIZE, k);
    write_size(imm_pkg::REG_COLS_B, n);
  endtask

  task automatic run_matrices();
    int unsigned na, nb;
    na = clamp_dim(size_reg[imm_pkg::REG_ROWS_A]) * clamp_dim(size_reg[imm_pkg::REG_INNER_SIZE]);
    nb = clamp_dim(size_reg[imm_pkg::REG_INNER_SIZE]) * clamp_dim(size_reg[imm_pkg::REG_COLS_B]);
    while (na + nb > 0) begin
      if (nb == 0 || (na > 0 && $urandom_range(0, 1) == 0)) begin
        send_item(imm_pkg::CMD_LOAD_A, 16'($urandom()));
        na--;
      end else begin
        send_item(imm_pkg::CMD_LOAD_B, 16'($urandom()));
        nb--;
      end
    end
    send_item(imm_pkg::CMD_COMPUTE, 16'($urandom()));
  endtask

  task automatic compute_or_fill();
    if (reads_written()) begin
      send_item(imm_pkg::CMD_COMPUTE, 16'($urandom()));
    end else begin
      run_matrices();
    end
  endtask

  task automatic test_full_extremes();
    write_size(imm_pkg::REG_ROWS_A, 4'd1);
    write_size(imm_pkg::REG_COLS_B, 4'd1);
    for (int i = 0; i < 8; i++) send_item(imm_pkg::CMD_LOAD_A, -16'sd32768);
    for (int i = 0; i < 8; i++) send_item(imm_pkg::CMD_LOAD_B, -16'sd32768);
    send_item(imm_pkg::CMD_COMPUTE, 16'sd0);
    for (int i = 0; i < 8; i++) send_item(imm_pkg::CMD_LOAD_B, 16'sd32767);
    send_item(imm_pkg::CMD_COMPUTE, 16'sd0);
  endtask

  task automatic test_special_cases();
    set_sizes(4'd1, 4'd1, 4'd1);
    send_item(imm_pkg::CMD_LOAD_A, 16'sd32767);
    send_item(imm_pkg::CMD_NONE, 16'sd5);
    send_item(imm_pkg::CMD_LOAD_B, -16'sd32768);
    send_item(imm_pkg::CMD_COMPUTE, -16'sd1);
    send_item(imm_pkg::CMD_COMPUTE, 16'sd0);
    write_size(imm_pkg::REG_UNUSED, 4'd3);
    set_sizes(4'd0, 4'd0, 4'd0);
    compute_or_fill();
    set_sizes(4'd15, 4'd1, 4'd15);
    compute_or_fill();
    set_sizes(4'd0, 4'd15, 4'd0);
    compute_or_fill();
  endtask

  task automatic test_pointer_wrap();
    set_sizes(4'd1, 4'd1, 4'd2);
    for (int i = 0; i < Depth + 1; i++) send_item(imm_pkg::CMD_LOAD_A, 16'($urandom()));
    send_item(imm_pkg::CMD_LOAD_B, 16'($urandom()));
    compute_or_fill();
  endtask

  function automatic logic [3:0] pick_dim();
    if ($urandom_range(0, 9) < 7) return 4'($urandom_range(1, 3));
    return 4'($urandom_range(0, 15));
  endfunction

  task automatic test_random(int target);
    int start;
    start = items_sent;
    while (items_sent - start < target) begin
      if ($urandom_range(0, 2) == 0) set_sizes(pick_dim(), pick_dim(), pick_dim());
      case ($urandom_range(0, 9))
        0: send_item(imm_pkg::CMD_NONE, 16'($urandom()));
        1: repeat ($urandom_range(1, 4)) send_item(imm_pkg::imm_cmd_t'($urandom_range(0, 1)),
                                                   16'($urandom()));
        2: compute_or_fill();
        default: run_matrices();
      endcase
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = imm_pkg::REG_ROWS_A;
    cfg_data = 4'd0;
    in_valid = 1'b0;
    cmd = imm_pkg::CMD_NONE;
    element_value = 16'sd0;
    for (int i = 0; i < 3; i++) size_reg[i] = 4'd8;
    a_ptr = '0;
    b_ptr = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_full_extremes();
    test_special_cases();
    test_pointer_wrap();
    test_random(20);
    wait_idle();
    quiet = 1;
    test_random(10);
    wait_idle();
    repeat (50) @(posedge clk);
    $display("Ran %0d load and compute items with %0d size writes; checked %0d products.",
             items_sent, settings_used, products_seen);
    if (errors == 0) begin
      $display("** integer_matrix_multiply_unit: PASSED **");
    end else begin
      $display("** integer_matrix_multiply_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    product_t p;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("** integer_matrix_multiply_unit: FAILED **");
      $finish;
    end
    if (!rst && out_valid && out_ready) begin
      products_seen++;
      if (product_queue.size() == 0) begin
        $error("unexpected product item row %0d col %0d", out_row, out_col);
        errors++;
      end else begin
        p = product_queue.pop_front();
        if (product_value !== p.value) begin
          $error("product_value expected %0d actual %0d", p.value, product_value);
          errors++;
        end
        if (out_row !== p.row) begin
          $error("out_row expected %0d actual %0d", p.row, out_row);
          errors++;
        end
        if (out_col !== p.col) begin
          $error("out_col expected %0d actual %0d", p.col, out_col);
          errors++;
        end
        if (last !== p.last) begin
          $error("last expected %0d actual %0d", p.last, last);
          errors++;
        end
      end
    end
  end

endmodule
